// ===== hw/rtl/tts_pkg.sv =====
// Shared types and constants for the three-target SPI master.
// Holds command codes, target codes, flash constants and stream field positions.
// No dependencies.
package tts_pkg;

    typedef enum logic [3:0] {
        OP_IDLE     = 4'd0,
        OP_REG_WR   = 4'd1,
        OP_REG_RD   = 4'd2,
        OP_DAC_WR   = 4'd3,
        OP_DAC_RD   = 4'd4,
        OP_FL_SEL   = 4'd5,
        OP_FL_XFER  = 4'd6,
        OP_FL_DESEL = 4'd7,
        OP_FL_WAIT  = 4'd8
    } op_t;

    typedef struct packed {
        logic sclk;
        logic frame;
        logic mosi;
    } pins_t;

    localparam logic [1:0] SEL_REG   = 2'd0;
    localparam logic [1:0] SEL_FLASH = 2'd1;
    localparam logic [1:0] SEL_DAC   = 2'd2;

    localparam int unsigned DAC_WORD_BITS = 16;

    localparam logic [7:0] FLASH_STATUS_CMD = 8'hD7;
    localparam logic [7:0] FLASH_READY_MASK = 8'h80;
    localparam logic [7:0] FLASH_FILL       = 8'hFF;

    localparam int unsigned S_DATA_W  = 48;
    localparam int unsigned S_USER_W  = 4;
    localparam int unsigned M_DATA_W  = 40;

    localparam int unsigned OUT_SCLK_BIT  = 0;
    localparam int unsigned OUT_FRAME_BIT = 1;
    localparam int unsigned OUT_MOSI_BIT  = 2;
    localparam int unsigned OUT_BUSY_BIT  = 3;
    localparam int unsigned OUT_DONE_BIT  = 4;
    localparam int unsigned OUT_RD_LSB    = 5;
    localparam int unsigned OUT_RD_MSB    = 36;

endpackage

// ===== hw/rtl/three_target_spi_master.sv =====
// Three-target SPI master (register, DAC and flash targets), one pin tick per request.
// Depends on tts_pkg for command codes, pin types and field positions.
// The result of a request is registered when it is accepted and shown from the next cycle on.
// Throughput: one request per cycle while the output is not stalled; a one-entry output register decouples the sides.
// Reset: synchronous, active low; clears all sequencer state and the output valid.
module three_target_spi_master
    import tts_pkg::*;
#(
    parameter int unsigned REG_ADDR_BITS = 8,
    parameter int unsigned REG_DATA_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // tdata: address[7:0], data[39:8], bit_count[45:40], miso[46], zero[47]
    input  logic [S_DATA_W-1:0] s_tdata,
    // tuser: operation[3:0]
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // tdata: sclk[0], frame[1], mosi[2], busy_res[3], done_res[4], read_data[36:5],
    // zero[39:37]
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int unsigned REG_WORD_BITS = REG_ADDR_BITS + 1 + REG_DATA_BITS;
    localparam logic [6:0] REG_END = 7'(6 + 2 * REG_WORD_BITS);
    localparam logic [6:0] DAC_END = 7'(6 + 2 * DAC_WORD_BITS);
    localparam logic [31:0] REG_DATA_MASK = 32'((64'd1 << REG_DATA_BITS) - 64'd1);
    localparam logic [31:0] REG_ADDR_MASK = 32'((64'd1 << REG_ADDR_BITS) - 64'd1);
    localparam logic [31:0] DAC_MASK = 32'((64'd1 << DAC_WORD_BITS) - 64'd1);

    typedef struct packed {
        pins_t       pins;
        logic [31:0] tx;
        logic [6:0]  phase;
        logic        rising;
    } ftick_t;

    function automatic pins_t preamble(input logic [1:0] sel, input logic [6:0] p);
        pins_t r;
        logic  b;
        b = (p < 7'd2) ? sel[0] : sel[1];
        if (p == 7'd4) begin
            r = '0;
        end else begin
            r = '{sclk: p[0], frame: 1'b1, mosi: b};
        end
        return r;
    endfunction

    function automatic ftick_t flash_tick(input logic [31:0] tx, input logic [6:0] r);
        ftick_t f;
        f.pins   = '{sclk: r[0], frame: 1'b1, mosi: tx[31]};
        f.tx     = r[0] ? (tx << 1) : tx;
        f.rising = r[0];
        f.phase  = r - 7'd1;
        return f;
    endfunction

    logic [7:0]  in_address;
    logic [31:0] in_data;
    logic [5:0]  in_bit_count;
    logic        in_miso;
    logic [3:0]  in_op;
    logic        s_accept;

    logic [6:0]  phase_reg, phase_next;
    op_t         cmd_reg, cmd_next;
    logic [31:0] tx_reg, tx_next;
    logic [31:0] rx_reg, rx_next;
    logic        pend_reg, pend_next;
    logic        fsel_reg, fsel_next;
    logic [1:0]  poll_reg, poll_next;

    pins_t       pins;
    logic        done;
    logic [31:0] fin_value;
    logic [5:0]  n_clamp;
    logic        reg_cmd;
    logic        lsb_word;
    logic        word_bit;
    logic [6:0]  word_end;
    logic [1:0]  word_sel;
    logic [6:0]  q;
    ftick_t      ft;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    assign in_address   = s_tdata[7:0];
    assign in_data      = s_tdata[39:8];
    assign in_bit_count = s_tdata[45:40];
    assign in_miso      = s_tdata[46];
    assign in_op        = s_tuser;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        pend_next  = pend_reg;
        fsel_next  = fsel_reg;
        poll_next  = poll_reg;
        pins       = '0;
        done       = 1'b0;
        fin_value  = '0;
        n_clamp    = in_bit_count;
        word_bit   = 1'b0;
        q          = '0;
        ft         = '0;

        if (cmd_next == OP_IDLE && in_op >= OP_REG_WR && in_op <= OP_FL_WAIT) begin
            cmd_next   = op_t'(in_op);
            phase_next = '0;
            rx_next    = '0;
            pend_next  = 1'b0;
            poll_next  = '0;
            tx_next    = '0;
            case (cmd_next)
                OP_REG_WR: begin
                    tx_next = ((in_data & REG_DATA_MASK) << (REG_ADDR_BITS + 1))
                            | (32'd1 << REG_ADDR_BITS)
                            | (32'(in_address) & REG_ADDR_MASK);
                end
                OP_REG_RD: begin
                    tx_next = 32'(in_address) & REG_ADDR_MASK;
                end
                OP_DAC_WR: begin
                    tx_next = {19'd0, in_address[4:0], in_data[7:0]};
                end
                OP_DAC_RD: begin
                    tx_next = (32'd1 << (DAC_WORD_BITS - 1)) | {19'd0, in_address[4:0], 8'd0};
                end
                OP_FL_XFER: begin
                    if (n_clamp == 6'd0) begin
                        n_clamp = 6'd1;
                    end else if (n_clamp > 6'd32) begin
                        n_clamp = 6'd32;
                    end
                    tx_next    = (n_clamp == 6'd32) ? in_data : (in_data << (6'd32 - n_clamp));
                    phase_next = {n_clamp, 1'b0};
                end
                default: begin
                end
            endcase
        end

        reg_cmd  = (cmd_next == OP_REG_WR) || (cmd_next == OP_REG_RD);
        lsb_word = reg_cmd;
        word_end = lsb_word ? REG_END : DAC_END;
        word_sel = lsb_word ? SEL_REG : SEL_DAC;

        if (cmd_next == OP_IDLE) begin
            if (fsel_next) begin
                pins = '{sclk: 1'b1, frame: 1'b1, mosi: 1'b0};
            end else begin
                pins = '0;
            end
        end else begin
            if (pend_next) begin
                if (reg_cmd) begin
                    rx_next = (rx_next >> 1) | (32'(in_miso) << (REG_DATA_BITS - 1));
                end else begin
                    rx_next = (rx_next << 1) | 32'(in_miso);
                end
            end
            pend_next = 1'b0;
            case (cmd_next)
                OP_REG_WR, OP_REG_RD, OP_DAC_WR, OP_DAC_RD: begin
                    word_bit = lsb_word ? tx_next[0] : tx_next[DAC_WORD_BITS-1];
                    if (phase_next < 7'd5) begin
                        pins       = preamble(word_sel, phase_next);
                        phase_next = phase_next + 7'd1;
                    end else if (phase_next == 7'd5) begin
                        pins       = '{sclk: 1'b0, frame: 1'b1, mosi: word_bit};
                        phase_next = phase_next + 7'd1;
                    end else if (phase_next < word_end) begin
                        q = phase_next - 7'd6;
                        if (!q[0]) begin
                            pins = '{sclk: 1'b1, frame: 1'b1, mosi: word_bit};
                            if (!lsb_word) begin
                                pend_next = 1'b1;
                            end
                        end else begin
                            if (lsb_word) begin
                                tx_next   = tx_next >> 1;
                                pend_next = 1'b1;
                            end else begin
                                tx_next = (tx_next << 1) & DAC_MASK;
                            end
                            word_bit = lsb_word ? tx_next[0] : tx_next[DAC_WORD_BITS-1];
                            pins     = '{sclk: 1'b0, frame: 1'b1, mosi: word_bit};
                        end
                        phase_next = phase_next + 7'd1;
                    end else begin
                        pins = '0;
                        if (cmd_next == OP_REG_RD) begin
                            fin_value = rx_next & REG_DATA_MASK;
                        end else if (cmd_next == OP_DAC_RD) begin
                            fin_value = {24'd0, rx_next[7:0]};
                        end
                        fsel_next = 1'b0;
                        done      = 1'b1;
                    end
                end
                OP_FL_SEL: begin
                    if (phase_next < 7'd5) begin
                        pins       = preamble(SEL_FLASH, phase_next);
                        phase_next = phase_next + 7'd1;
                    end else begin
                        pins      = '{sclk: 1'b1, frame: 1'b1, mosi: 1'b1};
                        fsel_next = 1'b1;
                        done      = 1'b1;
                    end
                end
                OP_FL_XFER: begin
                    if (phase_next == 7'd0) begin
                        pins      = '{sclk: 1'b1, frame: 1'b1, mosi: tx_next[31]};
                        fin_value = rx_next;
                        done      = 1'b1;
                    end else begin
                        ft         = flash_tick(tx_next, phase_next);
                        pins       = ft.pins;
                        tx_next    = ft.tx;
                        phase_next = ft.phase;
                        pend_next  = ft.rising;
                    end
                end
                OP_FL_DESEL: begin
                    if (phase_next == 7'd0) begin
                        pins       = '{sclk: 1'b1, frame: 1'b1, mosi: 1'b0};
                        phase_next = 7'd1;
                    end else begin
                        pins      = '0;
                        fsel_next = 1'b0;
                        done      = 1'b1;
                    end
                end
                OP_FL_WAIT: begin
                    case (poll_next)
                        2'd0: begin
                            if (phase_next < 7'd5) begin
                                pins       = preamble(SEL_FLASH, phase_next);
                                phase_next = phase_next + 7'd1;
                            end else begin
                                pins       = '{sclk: 1'b1, frame: 1'b1, mosi: 1'b1};
                                fsel_next  = 1'b1;
                                poll_next  = 2'd1;
                                tx_next    = {FLASH_STATUS_CMD, 24'd0};
                                phase_next = 7'd16;
                            end
                        end
                        2'd1: begin
                            ft         = flash_tick(tx_next, phase_next);
                            pins       = ft.pins;
                            tx_next    = ft.tx;
                            phase_next = ft.phase;
                            if (phase_next == 7'd0) begin
                                poll_next  = 2'd2;
                                tx_next    = {FLASH_FILL, 24'd0};
                                phase_next = 7'd16;
                            end
                        end
                        2'd2: begin
                            if (phase_next == 7'd0 && (rx_next[7:0] & FLASH_READY_MASK) != 8'd0) begin
                                pins      = '{sclk: 1'b1, frame: 1'b1, mosi: 1'b0};
                                poll_next = 2'd3;
                            end else begin
                                if (phase_next == 7'd0) begin
                                    tx_next    = {FLASH_FILL, 24'd0};
                                    phase_next = 7'd16;
                                end
                                ft         = flash_tick(tx_next, phase_next);
                                pins       = ft.pins;
                                tx_next    = ft.tx;
                                phase_next = ft.phase;
                                pend_next  = ft.rising;
                            end
                        end
                        default: begin
                            pins      = '0;
                            fsel_next = 1'b0;
                            fin_value = {24'd0, rx_next[7:0]};
                            done      = 1'b1;
                        end
                    endcase
                end
                default: begin
                    pins = '0;
                    done = 1'b1;
                end
            endcase
            if (done) begin
                cmd_next   = OP_IDLE;
                phase_next = '0;
                poll_next  = '0;
                pend_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            cmd_reg      <= OP_IDLE;
            tx_reg       <= '0;
            rx_reg       <= '0;
            pend_reg     <= 1'b0;
            fsel_reg     <= 1'b0;
            poll_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg    <= phase_next;
                cmd_reg      <= cmd_next;
                tx_reg       <= tx_next;
                rx_reg       <= rx_next;
                pend_reg     <= pend_next;
                fsel_reg     <= fsel_next;
                poll_reg     <= poll_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {3'd0, (done ? fin_value : 32'd0), done,
                            (cmd_next != OP_IDLE), pins.mosi, pins.frame, pins.sclk};
        end
    end

endmodule

// ===== hw/rtl/tts_checker.sv =====
// Port-level checker for the three-target SPI master, bound to the top level.
// Depends on tts_pkg for the result field positions.
module tts_checker
    import tts_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A finished command never reports itself as still running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OUT_DONE_BIT] && m_tdata[OUT_BUSY_BIT]))
        else $error("done and busy set in the same result");

    // Read data is only carried on a done tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[OUT_DONE_BIT]) |-> (m_tdata[OUT_RD_MSB:OUT_RD_LSB] == 32'd0))
        else $error("read data nonzero outside a done tick");

    // An empty output register must leave the input side open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while no result is pending");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Every accepted request produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted request without a result");

endmodule

bind three_target_spi_master tts_checker u_tts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/three_target_spi_master_tb.sv =====
// Self-checking testbench for three_target_spi_master: directed commands, then random ones.
// Expected ticks come from a cycle model of the sequencer or a directed row; compared per field.
// Depends on tts_pkg and the three_target_spi_master RTL.
module three_target_spi_master_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tts_pkg::*;

    localparam int unsigned REG_ADDR_BITS = 8;
    localparam int unsigned REG_DATA_BITS = 16;
    localparam int unsigned REG_WORD_BITS = REG_ADDR_BITS + 1 + REG_DATA_BITS;
    localparam logic [31:0] REG_ADDR_MASK = (32'd1 << REG_ADDR_BITS) - 32'd1;
    localparam logic [31:0] REG_DATA_MASK = (32'd1 << REG_DATA_BITS) - 32'd1;
    localparam logic [31:0] DAC_WORD_MASK = (32'd1 << DAC_WORD_BITS) - 32'd1;
    localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
    localparam logic [6:0] PRE_TICKS = 7'd5;
    localparam logic [6:0] BYTE_TICKS = 7'd16;
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_CODE_MAX = 4'hF;
    localparam int unsigned RANDOM_ITEMS = 100;
    localparam int unsigned LATE_LOW_TICKS = 60;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned IDLE_LIMIT = 2000;

    typedef enum logic [1:0] {MISO_RAND, MISO_LOW, MISO_HIGH, MISO_LATE} miso_mode_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        logic [3:0]          op;
        logic [7:0]          addr;
        logic [31:0]         data;
        logic [5:0]          nbits;
        miso_mode_t          mmode;
        logic [3:0]          filler;
        logic                known;
        logic [M_DATA_W-1:0] first_res;
    } cmd_row_t;

    localparam int unsigned N_DIR = 18;
    localparam cmd_row_t DIR_PLAN [N_DIR] = '{
        '{OP_IDLE,      8'h00, 32'h0000_0000, 6'd0,  MISO_RAND, OP_IDLE,     1'b1, 40'h00},
        '{OP_CODE_MAX,  8'hFF, 32'hFFFF_FFFF, 6'd63, MISO_HIGH, OP_IDLE,     1'b1, 40'h00},
        '{OP_UNUSED_LO, 8'h3C, 32'h0F0F_0F0F, 6'd7,  MISO_RAND, OP_IDLE,     1'b1, 40'h00},
        '{OP_REG_WR,    8'hFF, 32'hFFFF_FFFF, 6'd0,  MISO_HIGH, OP_REG_RD,   1'b1, 40'h0A},
        '{OP_REG_RD,    8'hA5, 32'h0000_0000, 6'd0,  MISO_RAND, OP_DAC_WR,   1'b0, 40'h00},
        '{OP_DAC_WR,    8'hFF, 32'hFFFF_FFFF, 6'd0,  MISO_HIGH, OP_FL_WAIT,  1'b1, 40'h0A},
        '{OP_DAC_RD,    8'h15, 32'h1234_5678, 6'd0,  MISO_RAND, OP_FL_XFER,  1'b0, 40'h00},
        '{OP_FL_XFER,   8'h00, 32'h0000_00A5, 6'd8,  MISO_RAND, OP_FL_DESEL, 1'b0, 40'h00},
        '{OP_FL_SEL,    8'h00, 32'h0000_0000, 6'd0,  MISO_RAND, OP_IDLE,     1'b1, 40'h0E},
        '{OP_FL_XFER,   8'h00, 32'h0000_0001, 6'd0,  MISO_LOW,  OP_REG_WR,   1'b0, 40'h00},
        '{OP_FL_XFER,   8'h00, 32'h8000_0001, 6'd63, MISO_RAND, OP_IDLE,     1'b0, 40'h00},
        '{OP_IDLE,      8'h00, 32'h0000_0000, 6'd0,  MISO_RAND, OP_IDLE,     1'b1, 40'h03},
        '{OP_FL_DESEL,  8'h00, 32'h0000_0000, 6'd0,  MISO_RAND, OP_FL_SEL,   1'b0, 40'h00},
        '{OP_FL_DESEL,  8'h00, 32'h0000_0000, 6'd0,  MISO_RAND, OP_IDLE,     1'b0, 40'h00},
        '{OP_FL_SEL,    8'h00, 32'h0000_0000, 6'd0,  MISO_RAND, OP_IDLE,     1'b0, 40'h00},
        '{OP_FL_WAIT,   8'h00, 32'h0000_0000, 6'd0,  MISO_LATE, OP_DAC_RD,   1'b0, 40'h00},
        '{OP_FL_SEL,    8'h00, 32'h0000_0000, 6'd0,  MISO_RAND, OP_IDLE,     1'b0, 40'h00},
        '{OP_REG_WR,    8'h5A, 32'h0000_C3A5, 6'd0,  MISO_RAND, OP_IDLE,     1'b0, 40'h00}
    };

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    three_target_spi_master #(
        .REG_ADDR_BITS(REG_ADDR_BITS),
        .REG_DATA_BITS(REG_DATA_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    op_t         sq_cmd = OP_IDLE;
    logic [6:0]  sq_phase = '0;
    logic [31:0] sq_tx = '0;
    logic [31:0] sq_rx = '0;
    logic        sq_due = 1'b0;
    logic        sq_flash_on = 1'b0;
    logic [1:0]  sq_poll = '0;
    logic        pin_c, pin_f, pin_d, cmd_done;
    logic [31:0] done_val;

    logic [M_DATA_W-1:0] pin_results_due [$];
    logic [M_DATA_W-1:0] want_res;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    rx_mode_t    stall_mode = RX_ALWAYS;
    logic [15:0] stall_pat = 16'h0001;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void drive_pins(input logic c, input logic f, input logic d);
        pin_c = c;
        pin_f = f;
        pin_d = d;
    endfunction

    function automatic void end_command(input logic [31:0] v);
        cmd_done = 1'b1;
        done_val = v;
        sq_cmd = OP_IDLE;
        sq_phase = '0;
        sq_poll = '0;
        sq_due = 1'b0;
    endfunction

    function automatic void target_preamble(input logic [1:0] tgt, input logic [6:0] p);
        if (p == PRE_TICKS - 7'd1) begin
            drive_pins(1'b0, 1'b0, 1'b0);
        end else begin
            drive_pins(p[0], 1'b1, (p < 7'd2) ? tgt[0] : tgt[1]);
        end
    endfunction

    function automatic logic serial_out_bit(input logic lsb_first);
        return lsb_first ? sq_tx[0] : sq_tx[DAC_WORD_BITS-1];
    endfunction

    function automatic void shift_word_tick(input logic lsb_first);
        logic [6:0]  p;
        int unsigned w;
        logic [31:0] v;
        p = sq_phase;
        w = lsb_first ? REG_WORD_BITS : DAC_WORD_BITS;
        v = '0;
        if (p < PRE_TICKS) begin
            target_preamble(lsb_first ? SEL_REG : SEL_DAC, p);
        end else if (p == PRE_TICKS) begin
            drive_pins(1'b0, 1'b1, serial_out_bit(lsb_first));
        end else if (int'(p) < 6 + 2 * w) begin
            if (!p[0]) begin
                drive_pins(1'b1, 1'b1, serial_out_bit(lsb_first));
                if (!lsb_first) sq_due = 1'b1;
            end else begin
                if (lsb_first) sq_tx = sq_tx >> 1;
                else sq_tx = (sq_tx << 1) & DAC_WORD_MASK;
                drive_pins(1'b0, 1'b1, serial_out_bit(lsb_first));
                if (lsb_first) sq_due = 1'b1;
            end
        end else begin
            drive_pins(1'b0, 1'b0, 1'b0);
            if (sq_cmd == OP_REG_RD) v = sq_rx & REG_DATA_MASK;
            if (sq_cmd == OP_DAC_RD) v = sq_rx & BYTE_MASK;
            sq_flash_on = 1'b0;
            end_command(v);
            return;
        end
        sq_phase = p + 7'd1;
    endfunction

    function automatic void stream_bit_tick(input logic sample);
        logic [6:0] r;
        logic       b;
        r = sq_phase;
        b = sq_tx[31];
        if (!r[0]) begin
            drive_pins(1'b0, 1'b1, b);
        end else begin
            drive_pins(1'b1, 1'b1, b);
            sq_tx = sq_tx << 1;
            if (sample) sq_due = 1'b1;
        end
        sq_phase = r - 7'd1;
    endfunction

    function automatic logic [M_DATA_W-1:0] predict_pins(input logic [3:0] op,
            input logic [7:0] addr, input logic [31:0] data, input logic [5:0] nbits,
            input logic miso);
        logic [5:0]          n;
        logic [M_DATA_W-1:0] res;
        cmd_done = 1'b0;
        done_val = '0;
        if (sq_cmd == OP_IDLE && op >= OP_REG_WR && op <= OP_FL_WAIT) begin
            sq_cmd = op_t'(op);
            sq_phase = '0;
            sq_rx = '0;
            sq_due = 1'b0;
            sq_poll = '0;
            sq_tx = '0;
            case (sq_cmd)
                OP_REG_WR, OP_REG_RD: begin
                    sq_tx = (((sq_cmd == OP_REG_WR) ? (data & REG_DATA_MASK) : 32'd0)
                                << (REG_ADDR_BITS + 1))
                          | (32'(sq_cmd == OP_REG_WR) << REG_ADDR_BITS)
                          | (32'(addr) & REG_ADDR_MASK);
                end
                OP_DAC_WR, OP_DAC_RD: begin
                    sq_tx = {16'd0, sq_cmd == OP_DAC_RD, 2'b00, addr[4:0],
                             (sq_cmd == OP_DAC_WR) ? data[7:0] : 8'd0};
                end
                OP_FL_XFER: begin
                    n = (nbits == 6'd0) ? 6'd1 : ((nbits > 6'd32) ? 6'd32 : nbits);
                    sq_tx = (n == 6'd32) ? data : (data << (6'd32 - n));
                    sq_phase = {n, 1'b0};
                end
                default: ;
            endcase
        end
        if (sq_cmd == OP_IDLE) begin
            drive_pins(sq_flash_on, sq_flash_on, 1'b0);
        end else begin
            if (sq_due) begin
                if (sq_cmd == OP_REG_WR || sq_cmd == OP_REG_RD)
                    sq_rx = (sq_rx >> 1) | (32'(miso) << (REG_DATA_BITS - 1));
                else
                    sq_rx = (sq_rx << 1) | 32'(miso);
            end
            sq_due = 1'b0;
            case (sq_cmd)
                OP_REG_WR, OP_REG_RD: shift_word_tick(1'b1);
                OP_DAC_WR, OP_DAC_RD: shift_word_tick(1'b0);
                OP_FL_SEL: begin
                    if (sq_phase < PRE_TICKS) begin
                        target_preamble(SEL_FLASH, sq_phase);
                        sq_phase = sq_phase + 7'd1;
                    end else begin
                        drive_pins(1'b1, 1'b1, 1'b1);
                        sq_flash_on = 1'b1;
                        end_command('0);
                    end
                end
                OP_FL_XFER: begin
                    if (sq_phase == '0) begin
                        drive_pins(1'b1, 1'b1, sq_tx[31]);
                        end_command(sq_rx);
                    end else begin
                        stream_bit_tick(1'b1);
                    end
                end
                OP_FL_DESEL: begin
                    if (sq_phase == '0) begin
                        drive_pins(1'b1, 1'b1, 1'b0);
                        sq_phase = 7'd1;
                    end else begin
                        drive_pins(1'b0, 1'b0, 1'b0);
                        sq_flash_on = 1'b0;
                        end_command('0);
                    end
                end
                OP_FL_WAIT: begin
                    case (sq_poll)
                        2'd0: begin
                            if (sq_phase < PRE_TICKS) begin
                                target_preamble(SEL_FLASH, sq_phase);
                                sq_phase = sq_phase + 7'd1;
                            end else begin
                                drive_pins(1'b1, 1'b1, 1'b1);
                                sq_flash_on = 1'b1;
                                sq_poll = 2'd1;
                                sq_tx = {FLASH_STATUS_CMD, 24'd0};
                                sq_phase = BYTE_TICKS;
                            end
                        end
                        2'd1: begin
                            stream_bit_tick(1'b0);
                            if (sq_phase == '0) begin
                                sq_poll = 2'd2;
                                sq_tx = {FLASH_FILL, 24'd0};
                                sq_phase = BYTE_TICKS;
                            end
                        end
                        2'd2: begin
                            if (sq_phase == '0) begin
                                if ((sq_rx[7:0] & FLASH_READY_MASK) != 8'd0) begin
                                    drive_pins(1'b1, 1'b1, 1'b0);
                                    sq_poll = 2'd3;
                                end else begin
                                    sq_tx = {FLASH_FILL, 24'd0};
                                    sq_phase = BYTE_TICKS;
                                    stream_bit_tick(1'b1);
                                end
                            end else begin
                                stream_bit_tick(1'b1);
                            end
                        end
                        default: begin
                            drive_pins(1'b0, 1'b0, 1'b0);
                            sq_flash_on = 1'b0;
                            end_command(sq_rx & BYTE_MASK);
                        end
                    endcase
                end
                default: begin
                    drive_pins(1'b0, 1'b0, 1'b0);
                    end_command('0);
                end
            endcase
        end
        res = '0;
        res[OUT_SCLK_BIT] = pin_c;
        res[OUT_FRAME_BIT] = pin_f;
        res[OUT_MOSI_BIT] = pin_d;
        res[OUT_BUSY_BIT] = (sq_cmd != OP_IDLE);
        res[OUT_DONE_BIT] = cmd_done;
        res[OUT_RD_MSB:OUT_RD_LSB] = cmd_done ? done_val : 32'd0;
        return res;
    endfunction

    function automatic logic miso_level(input miso_mode_t mode, input int unsigned k);
        case (mode)
            MISO_LOW:  return 1'b0;
            MISO_HIGH: return 1'b1;
            MISO_LATE: return (k >= LATE_LOW_TICKS);
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_tick(input logic [3:0] op, input logic [7:0] addr,
            input logic [31:0] data, input logic [5:0] nbits, input logic miso,
            input logic known, input logic [M_DATA_W-1:0] known_res);
        int unsigned         gap;
        logic [M_DATA_W-1:0] pred;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, miso, nbits, data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = predict_pins(op, addr, data, nbits, miso);
        pin_results_due.push_back(known ? known_res : pred);
        items_sent++;
    endtask

    task automatic run_command(input cmd_row_t row);
        int unsigned k;
        k = 0;
        send_tick(row.op, row.addr, row.data, row.nbits, miso_level(row.mmode, k),
                  row.known, row.first_res);
        while (sq_cmd != OP_IDLE) begin
            k++;
            send_tick(row.filler, 8'($urandom), $urandom, 6'($urandom),
                      miso_level(row.mmode, k), 1'b0, '0);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] e,
            input logic [31:0] a);
        if (a !== e) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pin_results_due.size() == 0) begin
                $display("%0t: result with no request pending, expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want_res = pin_results_due.pop_front();
                check_field("sclk", 32'(want_res[OUT_SCLK_BIT]), 32'(m_tdata[OUT_SCLK_BIT]));
                check_field("frame", 32'(want_res[OUT_FRAME_BIT]),
                            32'(m_tdata[OUT_FRAME_BIT]));
                check_field("mosi", 32'(want_res[OUT_MOSI_BIT]), 32'(m_tdata[OUT_MOSI_BIT]));
                check_field("busy_res", 32'(want_res[OUT_BUSY_BIT]),
                            32'(m_tdata[OUT_BUSY_BIT]));
                check_field("done_res", 32'(want_res[OUT_DONE_BIT]),
                            32'(m_tdata[OUT_DONE_BIT]));
                check_field("read_data", want_res[OUT_RD_MSB:OUT_RD_LSB],
                            m_tdata[OUT_RD_MSB:OUT_RD_LSB]);
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = rx_mode_t'($urandom_range(0, 2));
            stall_left = $urandom_range(20, 120);
            stall_pat = 16'($urandom) | 16'h0001;
        end else begin
            stall_left--;
        end
        case (stall_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            default: begin
                m_tready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL three_target_spi_master");
            $finish;
        end
    end

    initial begin
        cmd_row_t    row;
        int unsigned base;
        int unsigned pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (DIR_PLAN[i]) run_command(DIR_PLAN[i]);
        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 11);
            if (pick <= 8) row.op = 4'(pick);
            else if (pick == 9) row.op = 4'($urandom_range(OP_UNUSED_LO, OP_CODE_MAX));
            else row.op = OP_FL_XFER;
            row.addr = 8'($urandom);
            row.data = $urandom;
            row.nbits = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(1, 32));
            case ($urandom_range(0, 5))
                0:       row.mmode = (row.op == OP_FL_WAIT) ? MISO_RAND : MISO_LOW;
                1:       row.mmode = MISO_HIGH;
                2:       row.mmode = MISO_LATE;
                default: row.mmode = MISO_RAND;
            endcase
            row.filler = ($urandom_range(0, 1) == 0) ? OP_IDLE : 4'($urandom_range(0, 15));
            row.known = 1'b0;
            row.first_res = '0;
            run_command(row);
        end
        s_tvalid <= 1'b0;
        while (pin_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS three_target_spi_master");
        end else begin
            $display("FAIL three_target_spi_master");
        end
        $finish;
    end

endmodule
